### rtl/cbal_pkg.sv
package cbal_pkg;

    typedef enum logic [1:0] {
        ACT_POINT,
        ACT_DERIV,
        ACT_ARC,
        ACT_FIND
    } action_t;

    // Item state that travels down the pipeline next to the arithmetic.
    typedef struct packed {
        action_t     action;
        logic [23:0] target;
        logic [16:0] param;
        logic [23:0] out_x;
        logic [23:0] out_y;
        logic [23:0] arc;
    } side_t;

    // Derivative coefficients of one axis: B'(t) = a t^2 + b t + c.
    typedef struct packed {
        logic signed [20:0] a;
        logic signed [20:0] b;
        logic signed [20:0] c;
    } coef_t;

    localparam int          SQRT_STEPS   = 20;
    localparam logic [16:0] PARAM_ONE    = 17'd65536;
    localparam logic [16:0] BISECT_START = 17'd32768;
    localparam logic [16:0] BISECT_STEP0 = 17'd16384;
    localparam logic [41:0] ARC_BIAS     = 42'd196608;
    localparam logic [24:0] DIV3_MUL     = 25'd22369622;

    function automatic logic [23:0] sat_s24(input logic signed [27:0] v);
        logic [23:0] r;
        if (v > 28'sd8388607)
        begin
            r = 24'h7FFFFF;
        end
        else if (v < -28'sd8388608)
        begin
            r = 24'h800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

### rtl/cubic_bezier_arc_length_evaluator.sv
// Cubic Bezier evaluator with Simpson arc length and bisection inverse.
// Control points are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not
// enforce; index 2*i is point i x, 2*i+1 is point i y, signed Q8.8.
// Each input item (action, param, target_length) gives one result item:
// the point, the derivative, the arc length over [0,param], or the
// parameter whose arc length meets target_length.
// The pipeline is a Bernstein section of six stages followed by one arc
// length unit of 30 stages per bisection step, each unit followed by a
// stage that moves the bisection estimate. One item is accepted in every
// cycle while in_stall is low.
// When out_stall holds a result, the next result lands in a skid register
// and in_stall rises in the following cycle, freezing the whole pipeline
// until the skid register drains; nothing is lost or repeated.
// Reset clears all valid bits and sets every control point to zero.
module cubic_bezier_arc_length_evaluator #(
    parameter int BISECT_STEPS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [16:0]        param,
    input  logic [23:0]        target_length,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] value_x,
    output logic signed [23:0] value_y,
    output logic [23:0]        arc_length,
    output logic [15:0]        found_param
);

    logic [15:0] cfg_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Power-form coefficients per axis, recomputed from the control points.
    logic signed [19:0] c3_reg [2], c3_next [2];
    logic signed [19:0] c2_reg [2], c2_next [2];
    logic signed [19:0] c1_reg [2], c1_next [2];
    logic signed [15:0] p0_reg [2];
    cbal_pkg::coef_t    coef_reg [2], coef_next [2];

    always_comb
    begin
        logic signed [15:0] q0, q1, q2, q3;
        for (int ax = 0; ax < 2; ax++)
        begin
            q0 = cfg_reg[ax];
            q1 = cfg_reg[2 + ax];
            q2 = cfg_reg[4 + ax];
            q3 = cfg_reg[6 + ax];
            c3_next[ax] = q3 - 20'sd3 * q2 + 20'sd3 * q1 - q0;
            c2_next[ax] = 20'sd3 * (q0 - 20'sd2 * q1 + q2);
            c1_next[ax] = 20'sd3 * (q1 - q0);
            coef_next[ax].a = 21'sd3 * c3_next[ax];
            coef_next[ax].b = 21'sd2 * c2_next[ax];
            coef_next[ax].c = c1_next[ax];
        end
    end

    always_ff @(posedge clk)
    begin
        c3_reg   <= c3_next;
        c2_reg   <= c2_next;
        c1_reg   <= c1_next;
        coef_reg <= coef_next;
        p0_reg[0] <= cfg_reg[0];
        p0_reg[1] <= cfg_reg[1];
    end

    logic en;
    logic out_valid_reg, skid_valid_reg;
    cbal_pkg::side_t out_side_reg, skid_side_reg;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // Input stage.
    logic            i_v_reg;
    cbal_pkg::side_t i_side_reg, i_side_next;

    always_comb
    begin
        i_side_next        = '0;
        i_side_next.action = cbal_pkg::action_t'(action);
        i_side_next.target = target_length;
        i_side_next.param  = (param > cbal_pkg::PARAM_ONE) ? cbal_pkg::PARAM_ONE : param;
        if (i_side_next.action == cbal_pkg::ACT_FIND)
        begin
            i_side_next.param = cbal_pkg::BISECT_START;
        end
    end

    // Bernstein point by Horner steps, the wide products split in two.
    logic [5:0]         h_v_reg;
    cbal_pkg::side_t    h_side_reg [6], h_side_next [6];
    logic signed [37:0] h1_m_reg  [2], h1_m_next  [2];
    logic signed [38:0] h2_x_reg  [2], h2_x_next  [2];
    logic signed [37:0] h3_ph_reg [2], h3_ph_next [2];
    logic        [35:0] h3_pl_reg [2], h3_pl_next [2];
    logic signed [55:0] h4_x_reg  [2], h4_x_next  [2];
    logic signed [45:0] h5_ph_reg [2], h5_ph_next [2];
    logic        [44:0] h5_pl_reg [2], h5_pl_next [2];
    logic        [23:0] h6_r      [2];

    always_comb
    begin
        logic signed [19:0] hi3;
        logic        [18:0] lo3;
        logic signed [27:0] hi5;
        logic        [27:0] lo5;
        logic signed [73:0] acc;
        logic        [16:0] s1, s3, s5;
        s1 = i_side_reg.param;
        s3 = h_side_reg[1].param;
        s5 = h_side_reg[3].param;
        for (int ax = 0; ax < 2; ax++)
        begin
            h1_m_next[ax]  = c3_reg[ax] * $signed({1'b0, s1});
            h2_x_next[ax]  = h1_m_reg[ax] + (c2_reg[ax] <<< 16);
            hi3 = h2_x_reg[ax][38:19];
            lo3 = h2_x_reg[ax][18:0];
            h3_ph_next[ax] = hi3 * $signed({1'b0, s3});
            h3_pl_next[ax] = lo3 * s3;
            h4_x_next[ax]  = (h3_ph_reg[ax] <<< 19) + $signed({1'b0, h3_pl_reg[ax]})
                           + (c1_reg[ax] <<< 32);
            hi5 = h4_x_reg[ax][55:28];
            lo5 = h4_x_reg[ax][27:0];
            h5_ph_next[ax] = hi5 * $signed({1'b0, s5});
            h5_pl_next[ax] = lo5 * s5;
            acc = (h5_ph_reg[ax] <<< 28) + $signed({1'b0, h5_pl_reg[ax]})
                + (p0_reg[ax] <<< 48) + (74'sd1 <<< 47);
            h6_r[ax] = cbal_pkg::sat_s24({{2{acc[73]}}, acc[73:48]});
        end
        h_side_next[0] = i_side_reg;
        for (int k = 1; k < 6; k++)
        begin
            h_side_next[k] = h_side_reg[k-1];
        end
        if (h_side_reg[4].action == cbal_pkg::ACT_POINT)
        begin
            h_side_next[5].out_x = h6_r[0];
            h_side_next[5].out_y = h6_r[1];
        end
    end

    // Arc length units, one per bisection step, each with an update stage.
    logic                      u_in_v    [BISECT_STEPS];
    cbal_pkg::side_t           u_in_side [BISECT_STEPS];
    logic                      u_out_v    [BISECT_STEPS];
    cbal_pkg::side_t           u_out_side [BISECT_STEPS];
    logic [23:0]               u_out_len  [BISECT_STEPS];
    logic [BISECT_STEPS-1:0]   p_v_reg;
    cbal_pkg::side_t           p_side_reg  [BISECT_STEPS];
    cbal_pkg::side_t           p_side_next [BISECT_STEPS];

    for (genvar k = 0; k < BISECT_STEPS; k++)
    begin : g_step
        localparam logic [16:0] STEP = cbal_pkg::BISECT_STEP0 >> k;

        if (k == 0)
        begin : g_first
            assign u_in_v[k]    = h_v_reg[5];
            assign u_in_side[k] = h_side_reg[5];
        end
        else
        begin : g_next
            assign u_in_v[k]    = p_v_reg[k-1];
            assign u_in_side[k] = p_side_reg[k-1];
        end

        cbal_arc u_arc (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (u_in_v[k]),
            .in_side   (u_in_side[k]),
            .coef_x    (coef_reg[0]),
            .coef_y    (coef_reg[1]),
            .out_valid (u_out_v[k]),
            .out_side  (u_out_side[k]),
            .out_len   (u_out_len[k])
        );

        always_comb
        begin
            p_side_next[k] = u_out_side[k];
            if (u_out_side[k].action == cbal_pkg::ACT_FIND)
            begin
                if (u_out_side[k].target < u_out_len[k])
                begin
                    p_side_next[k].param = u_out_side[k].param - STEP;
                end
                else
                begin
                    p_side_next[k].param = u_out_side[k].param + STEP;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                p_v_reg[k] <= u_out_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_side_reg[k] <= p_side_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_v_reg <= 1'b0;
            h_v_reg <= '0;
        end
        else if (en)
        begin
            i_v_reg <= in_valid;
            h_v_reg <= {h_v_reg[4:0], i_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_side_reg <= i_side_next;
            h_side_reg <= h_side_next;
            h1_m_reg   <= h1_m_next;
            h2_x_reg   <= h2_x_next;
            h3_ph_reg  <= h3_ph_next;
            h3_pl_reg  <= h3_pl_next;
            h4_x_reg   <= h4_x_next;
            h5_ph_reg  <= h5_ph_next;
            h5_pl_reg  <= h5_pl_next;
        end
    end

    // Output register with a skid register behind it.
    logic            take;
    logic            out_valid_next, skid_valid_next;
    cbal_pkg::side_t out_side_next, skid_side_next;

    assign take = p_v_reg[BISECT_STEPS-1] && en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_side_next   = out_side_reg;
        skid_valid_next = skid_valid_reg;
        skid_side_next  = skid_side_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_side_next   = skid_side_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take;
                out_side_next  = p_side_reg[BISECT_STEPS-1];
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_side_next  = p_side_reg[BISECT_STEPS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_side_reg  <= out_side_next;
        skid_side_reg <= skid_side_next;
    end

    assign out_valid   = out_valid_reg;
    assign value_x     = out_side_reg.out_x;
    assign value_y     = out_side_reg.out_y;
    assign arc_length  = out_side_reg.arc;
    assign found_param = (out_side_reg.action == cbal_pkg::ACT_FIND) ?
                         out_side_reg.param[15:0] : 16'd0;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid register filled without a stalled result");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (arc_length == 24'd0
                       || (value_x == 24'sd0 && value_y == 24'sd0 && found_param == 16'd0)))
        else $error("result item carries fields of two actions");

endmodule

### rtl/cbal_arc.sv
module cbal_arc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cbal_pkg::side_t   in_side,
    input  cbal_pkg::coef_t   coef_x,
    input  cbal_pkg::coef_t   coef_y,
    output logic              out_valid,
    output cbal_pkg::side_t   out_side,
    output logic [23:0]       out_len
);

    localparam int NST   = 4 + 2 + cbal_pkg::SQRT_STEPS + 4;
    localparam int ST_D2 = 1;
    localparam int ST_D4 = 3;
    localparam int ST_F1 = NST - 4;
    localparam int ST_F4 = NST - 1;
    localparam int QL    = cbal_pkg::SQRT_STEPS - 1;

    function automatic logic [17:0] lane_t(input logic [16:0] s, input logic full);
        return full ? {s, 1'b0} : {1'b0, s};
    endfunction

    logic [NST-1:0]  v_reg;
    cbal_pkg::side_t side_reg  [NST];
    cbal_pkg::side_t side_next [NST];

    // Lanes 0 and 1 evaluate x and y at half the parameter, lanes 2 and 3 at the full one.
    logic signed [39:0] d1_m_reg  [4], d1_m_next  [4];
    logic signed [40:0] d2_x_reg  [4], d2_x_next  [4];
    logic signed [39:0] d3_ph_reg [4], d3_ph_next [4];
    logic        [37:0] d3_pl_reg [4], d3_pl_next [4];
    logic        [23:0] d4_d_reg  [4], d4_d_next  [4];
    logic        [39:0] s1_sq_reg [4], s1_sq_next [4];
    logic        [39:0] s1_c_reg  [2], s1_c_next  [2];
    logic        [40:0] s2_n_reg  [3], s2_n_next  [3];
    logic        [40:0] q_rem_reg  [cbal_pkg::SQRT_STEPS][3];
    logic        [40:0] q_rem_next [cbal_pkg::SQRT_STEPS][3];
    logic        [40:0] q_root_reg  [cbal_pkg::SQRT_STEPS][3];
    logic        [40:0] q_root_next [cbal_pkg::SQRT_STEPS][3];
    logic        [23:0] f1_sum_reg,  f1_sum_next;
    logic        [40:0] f2_prod_reg, f2_prod_next;
    logic        [24:0] f3_w_reg,    f3_w_next;
    logic        [23:0] f4_len_reg,  f4_len_next;

    always_comb
    begin
        cbal_pkg::coef_t    cf;
        logic        [17:0] t;
        logic signed [20:0] hi;
        logic        [19:0] lo;
        logic signed [61:0] sum;
        logic signed [19:0] dn;
        logic signed [39:0] sq;
        logic signed [41:0] csq;
        for (int l = 0; l < 4; l++)
        begin
            cf = ((l & 1) != 0) ? coef_y : coef_x;
            t  = lane_t(in_side.param, l >= 2);
            d1_m_next[l] = $signed(cf.a) * $signed({1'b0, t});
            d2_x_next[l] = d1_m_reg[l] + ($signed(cf.b) <<< 17);
            t  = lane_t(side_reg[ST_D2].param, l >= 2);
            hi = d2_x_reg[l][40:20];
            lo = d2_x_reg[l][19:0];
            d3_ph_next[l] = hi * $signed({1'b0, t});
            d3_pl_next[l] = lo * t;
            sum = (d3_ph_reg[l] <<< 20) + $signed({1'b0, d3_pl_reg[l]})
                + ($signed(cf.c) <<< 34) + (62'sd1 <<< 33);
            d4_d_next[l] = cbal_pkg::sat_s24(sum[61:34]);
            // The derivative stays well inside 19 bits, so the low bits are exact.
            dn = d4_d_reg[l][19:0];
            sq = dn * dn;
            s1_sq_next[l] = sq;
        end
        for (int j = 0; j < 2; j++)
        begin
            cf  = (j != 0) ? coef_y : coef_x;
            csq = $signed(cf.c) * $signed(cf.c);
            s1_c_next[j] = csq[39:0];
        end
        s2_n_next[0] = {1'b0, s1_c_reg[0]} + {1'b0, s1_c_reg[1]};
        s2_n_next[1] = {1'b0, s1_sq_reg[0]} + {1'b0, s1_sq_reg[1]};
        s2_n_next[2] = {1'b0, s1_sq_reg[2]} + {1'b0, s1_sq_reg[3]};
    end

    // One bit of the integer square root per stage, for all three norms.
    always_comb
    begin
        logic [40:0] rem_in;
        logic [40:0] root_in;
        logic [40:0] bitv;
        logic [40:0] trial;
        for (int k = 0; k < cbal_pkg::SQRT_STEPS; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rem_in  = (k == 0) ? s2_n_reg[j] : q_rem_reg[(k == 0) ? 0 : k - 1][j];
                root_in = (k == 0) ? '0 : q_root_reg[(k == 0) ? 0 : k - 1][j];
                bitv    = 41'd1 << (2 * (QL - k));
                trial   = root_in + bitv;
                if (rem_in >= trial)
                begin
                    q_rem_next[k][j]  = rem_in - trial;
                    q_root_next[k][j] = (root_in >> 1) + bitv;
                end
                else
                begin
                    q_rem_next[k][j]  = rem_in;
                    q_root_next[k][j] = root_in >> 1;
                end
            end
        end
    end

    always_comb
    begin
        logic [41:0] biased;
        logic [49:0] prod;
        f1_sum_next = 24'(q_root_reg[QL][0]) + (24'(q_root_reg[QL][1]) << 2)
                    + 24'(q_root_reg[QL][2]);
        f2_prod_next = 41'(side_reg[ST_F1].param) * 41'(f1_sum_reg);
        biased = {1'b0, f2_prod_reg} + cbal_pkg::ARC_BIAS;
        f3_w_next = biased[41:17];
        // Division by three as a multiply by the reciprocal of three scaled by 2^26, rounded up.
        prod = 50'(f3_w_reg) * 50'(cbal_pkg::DIV3_MUL);
        f4_len_next = prod[49:26];
    end

    always_comb
    begin
        side_next[0] = in_side;
        for (int i = 1; i < NST; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
        if (side_reg[ST_D4-1].action == cbal_pkg::ACT_DERIV)
        begin
            side_next[ST_D4].out_x = d4_d_next[2];
            side_next[ST_D4].out_y = d4_d_next[3];
        end
        if (side_reg[ST_F4-1].action == cbal_pkg::ACT_ARC)
        begin
            side_next[ST_F4].arc = f4_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg    <= side_next;
            d1_m_reg    <= d1_m_next;
            d2_x_reg    <= d2_x_next;
            d3_ph_reg   <= d3_ph_next;
            d3_pl_reg   <= d3_pl_next;
            d4_d_reg    <= d4_d_next;
            s1_sq_reg   <= s1_sq_next;
            s1_c_reg    <= s1_c_next;
            s2_n_reg    <= s2_n_next;
            q_rem_reg   <= q_rem_next;
            q_root_reg  <= q_root_next;
            f1_sum_reg  <= f1_sum_next;
            f2_prod_reg <= f2_prod_next;
            f3_w_reg    <= f3_w_next;
            f4_len_reg  <= f4_len_next;
        end
    end

    assign out_valid = v_reg[ST_F4];
    assign out_side  = side_reg[ST_F4];
    assign out_len   = f4_len_reg;

endmodule
